>>> src/svalloc_pkg.sv
// svalloc_pkg: shared types and constants for the voice slot allocator
// holds default sizes, field widths and the per-cell control bundle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package svalloc_pkg;

	// default sizing
	localparam int VOICES_DEF    = 16;
	localparam int TIME_BITS_DEF = 24;

	// fixed field widths of the beats
	localparam int TIME_FIELD_W  = 24;
	localparam int VOICE_FIELD_W = 4;
	localparam int COUNT_FIELD_W = 5;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic dec_en;   // apply the wait to opened cells
		logic wr_en;    // store into the selected cell
		logic later;    // reuse mark to store
		logic sets_dur; // also store a new remaining time
		logic tok_en;   // scan token moves this cycle
	} svalloc_ctrl_t;

endpackage

`default_nettype wire

>>> src/synth_voice_allocator_unit.sv
// synth_voice_allocator_unit: top level of the voice slot allocator
// a sequencer driving a chain of svalloc_cell slots, plus the result register
// depends on svalloc_pkg and svalloc_cell
`timescale 1ns / 1ps
`default_nettype none
// sequence: an accepted event first passes the decrement state; a continuing
//   event then goes to the write state, and any other event scans the chain
//   until the scan token stops at the first reusable slot or at the slot count
// flow: a new event waits until the current result loads; the token walks
//   one cell per cycle along the chain; a stalled result holds the input
// reset: arst_n clears all remaining times, reuse marks and the slot count

module synth_voice_allocator_unit #(
	parameter int VOICES    = svalloc_pkg::VOICES_DEF,
	parameter int TIME_BITS = svalloc_pkg::TIME_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// event beat
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire  [svalloc_pkg::TIME_FIELD_W-1:0]   wait_time,
	input  wire                                    has_previous,
	input  wire  [svalloc_pkg::VOICE_FIELD_W-1:0]  previous_voice,
	input  wire                                    later_used,
	input  wire                                    sets_duration,
	input  wire  [svalloc_pkg::TIME_FIELD_W-1:0]   new_duration,
	// result beat
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic [svalloc_pkg::VOICE_FIELD_W-1:0]  voice_index,
	output logic                                   fresh_voice,
	output logic                                   table_full,
	output logic [svalloc_pkg::COUNT_FIELD_W-1:0]  active_voices
);

	// slot index and slot count widths
	localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W = $clog2(VOICES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEC,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t state_q;

	// event fields captured at acceptance
	logic [TIME_BITS-1:0] wait_q;
	logic [TIME_BITS-1:0] dur_q;
	logic                 has_prev_q;
	logic [svalloc_pkg::VOICE_FIELD_W-1:0] prev_q;
	logic                 later_q;
	logic                 sets_dur_q;

	// decision of the current event
	logic [IDX_W-1:0]     voice_q;
	logic                 fresh_q;
	logic                 full_q;

	// allocator state outside the cells
	logic [CNT_W-1:0]     slot_count_q;
	logic [CNT_W-1:0]     idx_q;        // tracks the token position

	// result register
	logic                                  out_valid_q;
	logic [svalloc_pkg::VOICE_FIELD_W-1:0] voice_index_q;
	logic                                  fresh_voice_q;
	logic                                  table_full_q;
	logic [svalloc_pkg::COUNT_FIELD_W-1:0] active_voices_q;

	svalloc_pkg::svalloc_ctrl_t ctrl;
	logic              out_free;
	logic              in_take;
	logic              prev_in_range;
	logic [VOICES-1:0] tok_chain;  // token entering each cell
	logic [VOICES-1:0] hit;
	logic              hit_any;
	logic [CNT_W-1:0]  slot_count_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	// the result register can load when empty or when its beat leaves now
	assign out_free  = !out_valid_q || !out_stall;
	assign hit_any   = |hit;
	assign prev_in_range = 32'(prev_q) < VOICES;
	assign slot_count_next = slot_count_q + CNT_W'(fresh_q);

	// control broadcast to the chain
	always_comb begin
		ctrl.dec_en   = (state_q == ST_DEC);
		ctrl.wr_en    = (state_q == ST_WRITE) && out_free && !full_q;
		ctrl.later    = later_q;
		ctrl.sets_dur = sets_dur_q;
		// the token enters cell 0 at the decrement edge and walks during the scan
		ctrl.tok_en   = ((state_q == ST_DEC) && !has_prev_q) || (state_q == ST_SCAN);
	end

	// token injection at the head of the chain
	assign tok_chain[0] = (state_q == ST_DEC);

	genvar gi;
	generate
		for (gi = 0; gi < VOICES; gi++) begin : g_cell
			if (gi == VOICES - 1) begin : g_last
				svalloc_cell #(
					.TIME_BITS (TIME_BITS),
					.IDX_W     (IDX_W),
					.CNT_W     (CNT_W),
					.INDEX     (gi)
				) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.wait_val   (wait_q),
					.dur        (dur_q),
					.wr_voice   (voice_q),
					.slot_count (slot_count_q),
					.tok_in     (tok_chain[gi]),
					.tok_pass   (),
					.hit        (hit[gi])
				);
			end else begin : g_mid
				svalloc_cell #(
					.TIME_BITS (TIME_BITS),
					.IDX_W     (IDX_W),
					.CNT_W     (CNT_W),
					.INDEX     (gi)
				) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.wait_val   (wait_q),
					.dur        (dur_q),
					.wr_voice   (voice_q),
					.slot_count (slot_count_q),
					.tok_in     (tok_chain[gi]),
					.tok_pass   (tok_chain[gi+1]),
					.hit        (hit[gi])
				);
			end
		end
	endgenerate

	// sequencer, allocator bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			slot_count_q    <= '0;
			idx_q           <= '0;
			out_valid_q     <= 1'b0;
			wait_q          <= '0;
			dur_q           <= '0;
			has_prev_q      <= 1'b0;
			prev_q          <= '0;
			later_q         <= 1'b0;
			sets_dur_q      <= 1'b0;
			voice_q         <= '0;
			fresh_q         <= 1'b0;
			full_q          <= 1'b0;
			voice_index_q   <= '0;
			fresh_voice_q   <= 1'b0;
			table_full_q    <= 1'b0;
			active_voices_q <= '0;
		end else begin
			// a beat leaving while write loads the next is handled in write
			if (out_valid_q && !out_stall && (state_q != ST_WRITE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						wait_q     <= TIME_BITS'(wait_time);
						dur_q      <= TIME_BITS'(new_duration);
						has_prev_q <= has_previous;
						prev_q     <= previous_voice;
						later_q    <= later_used;
						sets_dur_q <= sets_duration;
						state_q    <= ST_DEC;
					end
				end
				ST_DEC: begin
					idx_q   <= '0;
					fresh_q <= 1'b0;
					if (has_prev_q) begin
						// continuing event keeps its voice, out of range counts as full
						full_q  <= !prev_in_range;
						voice_q <= prev_in_range ? IDX_W'(prev_q) : '0;
						state_q <= ST_WRITE;
					end else begin
						full_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == slot_count_q) begin
						// token ran past the opened slots
						if (slot_count_q == CNT_W'(VOICES)) begin
							full_q  <= 1'b1;
							voice_q <= '0;
						end else begin
							fresh_q <= 1'b1;
							voice_q <= IDX_W'(slot_count_q);
						end
						state_q <= ST_WRITE;
					end else if (hit_any) begin
						voice_q <= IDX_W'(idx_q);
						state_q <= ST_WRITE;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						slot_count_q    <= slot_count_next;
						out_valid_q     <= 1'b1;
						voice_index_q   <= svalloc_pkg::VOICE_FIELD_W'(voice_q);
						fresh_voice_q   <= fresh_q;
						table_full_q    <= full_q;
						active_voices_q <= svalloc_pkg::COUNT_FIELD_W'(slot_count_next);
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign voice_index   = voice_index_q;
	assign fresh_voice   = fresh_voice_q;
	assign table_full    = table_full_q;
	assign active_voices = active_voices_q;

endmodule

`default_nettype wire

>>> src/svalloc_cell.sv
// svalloc_cell: one voice slot of the allocator chain
// holds remaining time, reuse mark and the scan token stage
// depends on svalloc_pkg
`timescale 1ns / 1ps
`default_nettype none

module svalloc_cell #(
	parameter int TIME_BITS = svalloc_pkg::TIME_BITS_DEF,
	parameter int IDX_W     = 4,
	parameter int CNT_W     = 5,
	parameter int INDEX     = 0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire svalloc_pkg::svalloc_ctrl_t ctrl,
	input  wire  [TIME_BITS-1:0]      wait_val,
	input  wire  [TIME_BITS-1:0]      dur,
	input  wire  [IDX_W-1:0]          wr_voice,
	input  wire  [CNT_W-1:0]          slot_count,
	input  wire                       tok_in,
	output logic                      tok_pass,
	output logic                      hit
);

	logic [TIME_BITS-1:0] time_q;
	logic                 mark_q;
	logic                 tok_q;
	logic                 opened;
	logic                 free;
	logic [TIME_BITS-1:0] time_dec;

	assign opened   = slot_count > CNT_W'(INDEX);
	assign free     = opened && !mark_q && (time_q == '0);
	assign time_dec = (time_q < wait_val) ? '0 : (time_q - wait_val);
	assign hit      = tok_q && free;
	assign tok_pass = tok_q && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			mark_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= ctrl.tok_en ? tok_in : 1'b0;
			if (ctrl.dec_en && opened) begin
				time_q <= time_dec;
			end else if (ctrl.wr_en && (wr_voice == IDX_W'(INDEX))) begin
				mark_q <= ctrl.later;
				if (ctrl.sets_dur) begin
					time_q <= dur;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/svalloc_checker.sv
// svalloc_checker: port-level checks on the allocator result beats
// bound to synth_voice_allocator_unit; depends on svalloc_pkg
`timescale 1ns / 1ps
`default_nettype none

module svalloc_checker #(
	parameter int VOICES = svalloc_pkg::VOICES_DEF
) (
	input wire                                   clk,
	input wire                                   arst_n,
	input wire                                   out_valid,
	input wire                                   out_stall,
	input wire [svalloc_pkg::VOICE_FIELD_W-1:0]  voice_index,
	input wire                                   fresh_voice,
	input wire                                   table_full,
	input wire [svalloc_pkg::COUNT_FIELD_W-1:0]  active_voices
);

	// a full table never also opens a slot
	a_full_not_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fresh_voice && table_full))
		else $error("fresh and full in one beat");

	// a full table reports voice 0
	a_full_voice_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> voice_index == '0)
		else $error("full beat with nonzero voice");

	// a freshly opened slot is the last one counted
	a_fresh_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fresh_voice |->
			voice_index == svalloc_pkg::VOICE_FIELD_W'(active_voices - 5'd1))
		else $error("fresh voice does not match slot count");

	// slot count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(active_voices) <= VOICES)
		else $error("slot count beyond table size");

	// a stalled result beat stays valid with its voice and slot count held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(voice_index)
			&& $stable(active_voices))
		else $error("stalled beat changed");

endmodule

bind synth_voice_allocator_unit svalloc_checker #(.VOICES(VOICES)) u_svalloc_checker (.*);

`default_nettype wire
